/* rtl/core/mccl_pkg.sv */
// types, constants and state codes shared by the markov context code-length block
// no dependencies
package mccl_pkg;

    localparam int MAX_ALPHA   = 32;
    localparam int MAX_ORDER   = 8;
    localparam int TABLE_DEPTH = 4096;
    localparam int TOTAL_DEPTH = TABLE_DEPTH / 2;
    localparam int TAB_AW      = $clog2(TABLE_DEPTH);
    localparam int TOT_AW      = $clog2(TOTAL_DEPTH);
    localparam int HIST_AW     = $clog2(MAX_ORDER);
    localparam int CNT_W       = 32;
    localparam int LEN_W       = 21;
    localparam int FRAC_W      = 16;

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_FIT     = 2'd1;
    localparam logic [1:0] OP_PREDICT = 2'd2;
    localparam logic [1:0] OP_NOP     = 2'd3;

    localparam logic [0:0] REG_ALPHA = 1'd0;
    localparam logic [0:0] REG_ORDER = 1'd1;

    localparam logic [5:0] ALPHA_RESET = 6'd4;
    localparam logic [4:0] ORDER_RESET = 5'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [4:0] symbol;
        logic       seq_start;
    } in_item_t;

    typedef struct packed {
        logic [4:0]       candidate;
        logic [LEN_W-1:0] code_length;
        logic             last;
    } out_item_t;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_CTX,
        S_TWAIT,
        S_TUSE,
        S_LOG_NORM,
        S_LOG_SQ,
        S_CREQ,
        S_CUSE,
        S_EMIT
    } state_t;

endpackage

/* rtl/core/markov_context_code_length.sv */
// order-k markov context model with laplace counts, reporting code lengths
// depends on mccl_pkg; holds the count and total memories and a shared log2 unit
//
// Usage: items arrive on in_valid/in_stall with in_data, results leave on
// out_valid/out_stall with out_data; cfg_we/cfg_index/cfg_data write the
// alphabet size (index 0) and model order (index 1) while the block is idle.
// One item is handled at a time; in_stall is low only when the block is idle.
// After reset the block sweeps both memories before its first transfer; a
// clear item runs the same sweep. A fit with a full context runs the context
// build, one memory read and one update; otherwise it only shifts the history.
// A predict with a full context builds the context, then computes log2 of the
// total and of each symbol count in the one shared log2 unit: normalization
// plus 16 squaring steps per value, one 32x32 multiply each. Results come out
// one per candidate, candidate 0 upward, last marking the final one; with a
// uniform or short context every candidate gets log2 of the alphabet size.
// A result sits in the output register until out_stall is low; the sequencer
// waits meanwhile, so stalls only stretch the item.
module markov_context_code_length
    import mccl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_data,
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [5:0] cfg_data
);

    // memories
    logic [CNT_W-1:0] count_mem [TABLE_DEPTH];
    logic [CNT_W-1:0] total_mem [TOTAL_DEPTH];
    logic [CNT_W-1:0] cnt_rd, tot_rd;
    logic             cnt_we, tot_we;
    logic [TAB_AW-1:0] cnt_waddr, cnt_raddr;
    logic [TOT_AW-1:0] tot_waddr, tot_raddr;
    logic [CNT_W-1:0] cnt_wdata, tot_wdata;

    // control and datapath registers
    state_t            state_reg, state_next;
    logic [5:0]        alpha_reg, alpha_next;
    logic [4:0]        order_reg, order_next;
    logic [4:0]        hist_reg [MAX_ORDER];
    logic [4:0]        hist_next [MAX_ORDER];
    logic [3:0]        seen_reg, seen_next;
    logic [TAB_AW-1:0] sweep_reg, sweep_next;
    logic [5:0]        fill_reg, fill_next;
    logic [TAB_AW-1:0] ctx_reg, ctx_next;
    logic [HIST_AW-1:0] t_reg, t_next;
    logic [4:0]        sym_reg, sym_next;
    logic              fit_reg, fit_next;
    logic              have_reg, have_next;
    logic [4:0]        cand_reg, cand_next;
    logic [CNT_W-1:0]  m_reg, m_next;
    logic [4:0]        n_reg, n_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [3:0]        i_reg, i_next;
    logic              logtot_reg, logtot_next;
    logic [LEN_W-1:0]  lt_reg, lt_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;

    // effective settings
    logic [5:0] a_eff;
    logic       uniform;
    logic [3:0] k_eff;
    logic       have_ctx;
    logic [4:0] sym_clamp;
    logic [3:0] seen_start;

    // shared arithmetic
    logic [17:0]       ctx_mul;
    logic [TAB_AW-1:0] ctx_step;
    logic [4:0]        addr_sym;
    logic [17:0]       ci_mul;
    logic [2*CNT_W-1:0] sq;
    logic [CNT_W:0]    sq_sh;
    logic [FRAC_W-1:0] frac_set;
    logic              log_done;
    logic [LEN_W-1:0]  log_res;
    logic [LEN_W-1:0]  len_val;
    logic              push;

    always_comb
    begin
        a_eff = alpha_reg;
        if (alpha_reg < 6'd2) a_eff = 6'd2;
        if (alpha_reg > 6'(MAX_ALPHA)) a_eff = 6'(MAX_ALPHA);
        uniform = order_reg[4];
        k_eff = (order_reg[3:0] > 4'(MAX_ORDER)) ? 4'(MAX_ORDER) : order_reg[3:0];
        sym_clamp = (6'(in_data.symbol) >= a_eff) ? 5'(a_eff - 6'd1) : in_data.symbol;
        seen_start = in_data.seq_start ? 4'd0 : seen_reg;
        have_ctx = !uniform && (seen_start >= k_eff);
    end

    // address and multiply paths
    always_comb
    begin
        ctx_mul   = 18'(ctx_reg) * 18'(a_eff);
        ctx_step  = TAB_AW'(ctx_mul + 18'(hist_reg[t_reg]));
        addr_sym  = fit_reg ? sym_reg : cand_reg;
        ci_mul    = 18'(ctx_reg) * 18'(a_eff) + 18'(addr_sym);
        cnt_raddr = TAB_AW'(ci_mul);
        tot_raddr = ctx_reg[TOT_AW-1:0];
        sq        = 64'(m_reg) * 64'(m_reg);
        sq_sh     = sq[2*CNT_W-1:CNT_W-1];
        frac_set  = frac_reg | (FRAC_W'(1) << (4'd15 - i_reg));
    end

    // sequencer: next state, memory writes and outputs
    always_comb
    begin
        state_next     = state_reg;
        alpha_next     = alpha_reg;
        order_next     = order_reg;
        hist_next      = hist_reg;
        seen_next      = seen_reg;
        sweep_next     = sweep_reg;
        fill_next      = fill_reg;
        ctx_next       = ctx_reg;
        t_next         = t_reg;
        sym_next       = sym_reg;
        fit_next       = fit_reg;
        have_next      = have_reg;
        cand_next      = cand_reg;
        m_next         = m_reg;
        n_next         = n_reg;
        frac_next      = frac_reg;
        i_next         = i_reg;
        logtot_next    = logtot_reg;
        lt_next        = lt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        cnt_we    = 1'b0;
        tot_we    = 1'b0;
        cnt_waddr = cnt_raddr;
        tot_waddr = tot_raddr;
        cnt_wdata = cnt_rd + 32'd1;
        tot_wdata = tot_rd + 32'd1;
        log_done  = 1'b0;
        log_res   = '0;
        push      = 1'b0;
        len_val   = lt_reg;

        // configuration writes
        if (cfg_we)
        begin
            if (cfg_index == REG_ALPHA) alpha_next = cfg_data;
            if (cfg_index == REG_ORDER) order_next = cfg_data[4:0];
        end

        case (state_reg)
            S_SWEEP:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = sweep_reg;
                cnt_wdata = 32'd1;
                tot_we    = !sweep_reg[TAB_AW-1];
                tot_waddr = sweep_reg[TOT_AW-1:0];
                tot_wdata = 32'(fill_reg);
                sweep_next = sweep_reg + 1'b1;
                if (&sweep_reg) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.opcode == OP_CLEAR)
                    begin
                        fill_next  = a_eff;
                        sweep_next = '0;
                        state_next = S_SWEEP;
                    end
                    else if (in_data.opcode == OP_FIT || in_data.opcode == OP_PREDICT)
                    begin
                        sym_next  = sym_clamp;
                        seen_next = seen_start;
                        fit_next  = (in_data.opcode == OP_FIT);
                        have_next = have_ctx;
                        cand_next = '0;
                        ctx_next  = '0;
                        t_next    = HIST_AW'(k_eff - 4'd1);
                        if (have_ctx)
                            state_next = (k_eff == 4'd0) ? S_TWAIT : S_CTX;
                        else if (in_data.opcode == OP_FIT)
                            push = 1'b1;
                        else
                        begin
                            // uniform or short context: code length is log2 of the alphabet size
                            m_next      = 32'(a_eff);
                            n_next      = 5'd31;
                            frac_next   = '0;
                            i_next      = '0;
                            logtot_next = 1'b1;
                            state_next  = S_LOG_NORM;
                        end
                    end
                end
            end
            S_CTX:
            begin
                ctx_next = ctx_step;
                t_next   = t_reg - 1'b1;
                if (t_reg == '0) state_next = S_TWAIT;
            end
            S_TWAIT:
            begin
                state_next = S_TUSE;
            end
            S_TUSE:
            begin
                if (fit_reg)
                begin
                    // no update once the total has saturated
                    if (~&tot_rd)
                    begin
                        tot_we = 1'b1;
                        cnt_we = 1'b1;
                        if (&cnt_rd) cnt_wdata = cnt_rd;
                    end
                    push = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    m_next      = tot_rd;
                    n_next      = 5'd31;
                    frac_next   = '0;
                    i_next      = '0;
                    logtot_next = 1'b1;
                    state_next  = S_LOG_NORM;
                end
            end
            S_LOG_NORM:
            begin
                if (m_reg == '0)
                begin
                    log_done = 1'b1;
                    log_res  = '0;
                end
                else if (m_reg[CNT_W-1])
                    state_next = S_LOG_SQ;
                else
                begin
                    m_next = m_reg << 1;
                    n_next = n_reg - 1'b1;
                end
            end
            S_LOG_SQ:
            begin
                if (sq_sh[CNT_W])
                begin
                    m_next    = sq_sh[CNT_W:1];
                    frac_next = frac_set;
                end
                else
                    m_next = sq_sh[CNT_W-1:0];
                i_next = i_reg + 1'b1;
                if (i_reg == 4'd15)
                begin
                    log_done = 1'b1;
                    log_res  = {n_reg, sq_sh[CNT_W] ? frac_set : frac_reg};
                end
            end
            S_CREQ:
            begin
                state_next = S_CUSE;
            end
            S_CUSE:
            begin
                m_next      = cnt_rd;
                n_next      = 5'd31;
                frac_next   = '0;
                i_next      = '0;
                logtot_next = 1'b0;
                state_next  = S_LOG_NORM;
            end
            S_EMIT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (out_reg.last)
                    begin
                        push = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cand_next = cand_reg + 1'b1;
                        if (have_reg)
                            state_next = S_CREQ;
                        else
                        begin
                            out_valid_next        = 1'b1;
                            out_next.candidate    = cand_reg + 1'b1;
                            out_next.code_length  = lt_reg;
                            out_next.last         = (6'(cand_reg) + 6'd2 == a_eff);
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // finish of the log2 unit: total first, then each count
        if (log_done)
        begin
            if (logtot_reg)
            begin
                lt_next = log_res;
                if (have_reg)
                    state_next = S_CREQ;
                else
                begin
                    len_val    = log_res;
                    state_next = S_EMIT;
                end
            end
            else
            begin
                len_val    = (lt_reg > log_res) ? lt_reg - log_res : '0;
                state_next = S_EMIT;
            end
            if (state_next == S_EMIT)
            begin
                out_valid_next       = 1'b1;
                out_next.candidate   = cand_reg;
                out_next.code_length = len_val;
                out_next.last        = (6'(cand_reg) + 6'd1 == a_eff);
            end
        end

        // advance the context history
        if (push)
        begin
            for (int h = MAX_ORDER - 1; h > 0; h--)
                hist_next[h] = hist_reg[h-1];
            hist_next[0] = (state_reg == S_IDLE) ? sym_clamp : sym_reg;
            if ((state_reg == S_IDLE ? seen_start : seen_reg) != 4'd15)
                seen_next = (state_reg == S_IDLE ? seen_start : seen_reg) + 4'd1;
            else
                seen_next = 4'd15;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            alpha_reg     <= ALPHA_RESET;
            order_reg     <= ORDER_RESET;
            seen_reg      <= '0;
            sweep_reg     <= '0;
            fill_reg      <= ALPHA_RESET;
            out_valid_reg <= 1'b0;
            for (int h = 0; h < MAX_ORDER; h++)
                hist_reg[h] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            alpha_reg     <= alpha_next;
            order_reg     <= order_next;
            seen_reg      <= seen_next;
            sweep_reg     <= sweep_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            hist_reg      <= hist_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ctx_reg    <= ctx_next;
        t_reg      <= t_next;
        sym_reg    <= sym_next;
        fit_reg    <= fit_next;
        have_reg   <= have_next;
        cand_reg   <= cand_next;
        m_reg      <= m_next;
        n_reg      <= n_next;
        frac_reg   <= frac_next;
        i_reg      <= i_next;
        logtot_reg <= logtot_next;
        lt_reg     <= lt_next;
        out_reg    <= out_next;
    end

    // count memory
    always_ff @(posedge clk)
    begin
        if (cnt_we) count_mem[cnt_waddr] <= cnt_wdata;
        cnt_rd <= count_mem[cnt_raddr];
    end

    // total memory
    always_ff @(posedge clk)
    begin
        if (tot_we) total_mem[tot_waddr] <= tot_wdata;
        tot_rd <= total_mem[tot_raddr];
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTH
    // a result is only held while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> state_reg == S_EMIT)
        else $error("out_valid outside emit state");
    // no input transfer while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n) !in_stall |-> !out_valid)
        else $error("input taken with a result pending");
    // a delivered last result returns the block to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && out_data.last) |=> state_reg == S_IDLE)
        else $error("no return to idle after last result");
`endif

endmodule

/* verif/mccl_checker.sv */
// transfer monitor, code-length predictor and result comparator for markov_context_code_length
// depends on mccl_pkg; instantiated beside the block by tb_markov_context_code_length
`timescale 1ns / 100ps
module mccl_checker
    import mccl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  in_item_t   in_data,
    input  logic       out_valid,
    input  logic       out_stall,
    input  out_item_t  out_data,
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [5:0] cfg_data,
    output int         errors,
    output int         pending
);

    // shadow copy of the model state
    logic [31:0] counts [TABLE_DEPTH];
    logic [31:0] totals [TOTAL_DEPTH];
    logic [4:0]  history [MAX_ORDER];
    logic [3:0]  seen;
    logic [5:0]  alpha_reg;
    logic [4:0]  order_reg;
    out_item_t   lengths_q [$];

    // log2 in Q5.16, fraction by repeated squaring, truncated
    function automatic logic [31:0] log2_q16(logic [31:0] x);
        int n;
        logic [63:0] m;
        logic [31:0] r;
        if (x == 0)
            return 0;
        n = 0;
        while (n < 31 && (x >> (n + 1)) != 0)
            n++;
        m = ({32'd0, x} << (31 - n)) & 64'hFFFF_FFFF;
        r = n << 16;
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000)
            begin
                m = m >> 1;
                r[15 - i] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic int unsigned eff_alpha();
        if (alpha_reg < 2)
            return 2;
        if (alpha_reg > MAX_ALPHA)
            return MAX_ALPHA;
        return alpha_reg;
    endfunction

    function automatic int eff_order();
        if (order_reg[4])
            return -1;
        if (order_reg > MAX_ORDER)
            return MAX_ORDER;
        return order_reg;
    endfunction

    task automatic fill_model(int unsigned a);
        for (int i = 0; i < TABLE_DEPTH; i++)
            counts[i] = 32'd1;
        for (int i = 0; i < TOTAL_DEPTH; i++)
            totals[i] = a;
    endtask

    // apply one accepted input item, queue the code lengths it produces
    task automatic advance_model(in_item_t it);
        int unsigned a, sym, ctx, ti, ci;
        int k;
        bit have_ctx;
        logic [31:0] lt, lc, len;
        out_item_t o;
        a = eff_alpha();
        k = eff_order();
        if (it.opcode == OP_CLEAR)
        begin
            fill_model(a);
            return;
        end
        if (it.opcode != OP_FIT && it.opcode != OP_PREDICT)
            return;
        sym = it.symbol;
        if (sym >= a)
            sym = a - 1;
        if (it.seq_start)
            seen = 0;
        have_ctx = (k >= 0) && (seen >= k);
        ctx = 0;
        if (have_ctx)
            for (int t = k - 1; t >= 0; t--)
                ctx = (ctx * a + history[t]) % TABLE_DEPTH;
        ti = ctx % TOTAL_DEPTH;
        if (it.opcode == OP_FIT)
        begin
            if (have_ctx && totals[ti] != 32'hFFFF_FFFF)
            begin
                ci = (ctx * a + sym) % TABLE_DEPTH;
                totals[ti]++;
                if (counts[ci] != 32'hFFFF_FFFF)
                    counts[ci]++;
            end
        end
        else
        begin
            lt = have_ctx ? log2_q16(totals[ti]) : log2_q16(a);
            for (int unsigned j = 0; j < a; j++)
            begin
                len = lt;
                if (have_ctx)
                begin
                    lc = log2_q16(counts[(ctx * a + j) % TABLE_DEPTH]);
                    len = (lt > lc) ? lt - lc : 0;
                end
                o.candidate   = j[4:0];
                o.code_length = len[LEN_W-1:0];
                o.last        = (j + 1 == a);
                lengths_q.push_back(o);
            end
        end
        for (int t = MAX_ORDER - 1; t > 0; t--)
            history[t] = history[t - 1];
        history[0] = sym[4:0];
        if (seen < 15)
            seen++;
    endtask

    task automatic report(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    // sample transfers at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        if (!rst_n)
        begin
            alpha_reg = ALPHA_RESET;
            order_reg = ORDER_RESET;
            fill_model(ALPHA_RESET);
            for (int t = 0; t < MAX_ORDER; t++)
                history[t] = '0;
            seen = 0;
            lengths_q.delete();
            errors = 0;
        end
        else
        begin
            // result transfer
            if (out_valid && !out_stall)
            begin
                if (lengths_q.size() == 0)
                    report($sformatf("unexpected result cand=%0d", out_data.candidate));
                else
                begin
                    e = lengths_q.pop_front();
                    if (out_data.candidate !== e.candidate)
                        report($sformatf("candidate %0d exp %0d",
                                         out_data.candidate, e.candidate));
                    if (out_data.code_length !== e.code_length)
                        report($sformatf("code_length %h exp %h (cand %0d)",
                                         out_data.code_length, e.code_length, e.candidate));
                    if (out_data.last !== e.last)
                        report($sformatf("last %b exp %b (cand %0d)",
                                         out_data.last, e.last, e.candidate));
                end
            end
            // input transfer
            if (in_valid && !in_stall)
                advance_model(in_data);
            // register write
            if (cfg_we)
            begin
                if (cfg_index == REG_ALPHA)
                    alpha_reg = cfg_data;
                else
                    order_reg = cfg_data[4:0];
            end
        end
        pending = lengths_q.size();
    end

endmodule

/* verif/tb_markov_context_code_length.sv */
// stimulus and verdict for markov_context_code_length
// depends on mccl_pkg, markov_context_code_length and mccl_checker
`timescale 1ns / 100ps
module tb_markov_context_code_length;
    import mccl_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_data;
    logic       cfg_we;
    logic [0:0] cfg_index;
    logic [5:0] cfg_data;
    int         errors;
    int         pending;
    int         items_sent;
    bit         quiet;
    bit         held;
    int         cur_alpha;

    markov_context_code_length DUT (.*);

    mccl_checker u_checker (.*);

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // run limit
    initial
    begin
        #100ms;
        $display("Verification failed");
        $finish;
    end

    // receiver: random stall bursts, one long hold-off
    initial
    begin
        out_stall = 1'b0;
        held = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && items_sent >= 40)
            begin
                held = 1;
                out_stall <= 1'b1;
                repeat (300) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // offer one item and hold it until its transfer
    task automatic send(logic [1:0] op, logic [4:0] sym, bit start);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= '{opcode: op, symbol: sym, seq_start: start};
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // wait for the block to drain and go idle, then write a register
    task automatic write_reg(logic [0:0] idx, logic [5:0] val);
        @(negedge clk);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0 || in_stall);
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_ALPHA)
            cur_alpha = (val < 2) ? 2 : (val > MAX_ALPHA) ? MAX_ALPHA : val;
    endtask

    // well-formed sequences of fit and predict with some noise and broken starts
    task automatic run_sequences(int n_items);
        int done, len, r;
        logic [4:0] sym;
        done = 0;
        while (done < n_items)
        begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
            begin
                r = $urandom_range(0, 99);
                sym = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                  : 5'($urandom_range(0, cur_alpha - 1));
                if (r < 3)
                    send(OP_NOP, 5'($urandom), $urandom_range(0, 1));
                else
                begin
                    send((r < 72) ? OP_FIT : OP_PREDICT, sym,
                         (i == 0) || ($urandom_range(0, 19) == 0));
                    done++;
                end
            end
        end
    endtask

    // stimulus
    initial
    begin
        logic [5:0] alphas [8];
        logic [5:0] orders [8];
        alphas     = '{6'd4, 6'd2, 6'd32, 6'd0, 6'd63, 6'd7, 6'd1, 6'd5};
        orders     = '{6'd2, 6'd0, 6'd8, 6'h1F, 6'd15, 6'd3, 6'd1, 6'd5};
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_we     = 1'b0;
        cfg_index  = REG_ALPHA;
        cfg_data   = '0;
        items_sent = 0;
        quiet      = 0;
        cur_alpha  = ALPHA_RESET;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: short context, context build-up, out-of-range symbol, unused opcode
        send(OP_PREDICT, 5'd0, 1'b1);
        send(OP_FIT, 5'd1, 1'b0);
        send(OP_FIT, 5'd2, 1'b0);
        send(OP_FIT, 5'd3, 1'b0);
        send(OP_FIT, 5'd3, 1'b0);
        send(OP_PREDICT, 5'd31, 1'b0);
        send(OP_NOP, 5'd31, 1'b1);
        send(OP_PREDICT, 5'd2, 1'b0);
        send(OP_FIT, 5'd1, 1'b1);
        send(OP_PREDICT, 5'd1, 1'b0);
        // clear ignores seq_start, then predict over fresh counts
        send(OP_CLEAR, 5'd0, 1'b1);
        send(OP_PREDICT, 5'd3, 1'b0);
        // uniform model
        write_reg(REG_ORDER, 6'h1F);
        send(OP_FIT, 5'd2, 1'b1);
        send(OP_PREDICT, 5'd1, 1'b0);
        // order zero: every fit counts
        write_reg(REG_ORDER, 6'd0);
        send(OP_FIT, 5'd0, 1'b1);
        send(OP_FIT, 5'd0, 1'b0);
        send(OP_FIT, 5'd1, 1'b0);
        send(OP_PREDICT, 5'd0, 1'b1);

        // random phases over a range of settings, extremes included
        for (int p = 0; p < 8; p++)
        begin
            if (p == 7)
                quiet = 1;
            write_reg(REG_ALPHA, alphas[p]);
            write_reg(REG_ORDER, orders[p]);
            if (p % 3 == 0)
                send(OP_CLEAR, 5'($urandom), $urandom_range(0, 1));
            run_sequences(50);
        end

        // drain
        @(negedge clk);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (60) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
